// ----- rtl/stm_pkg.sv -----
package stm_pkg;

	// ring of timestamp entries
	localparam int RING_DEPTH = 64;
	localparam int RING_IW    = $clog2(RING_DEPTH);
	localparam int RING_CW    = RING_IW + 1;

	// stream buffer, counted in 2048-byte blocks
	localparam int MAX_BUF_BLOCKS = 8192;
	localparam int BLK_W          = 14;
	localparam int BLOCK_SHIFT    = 11;
	localparam int SIZE_W         = BLK_W + BLOCK_SHIFT;
	localparam int POS_W          = 24;

	// shared remainder unit: one quotient bit per cycle
	localparam int DIV_W     = 32 - BLOCK_SHIFT;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] CFG_BUF_BLOCKS = 2'd0;
	localparam logic [1:0] CFG_BUF_BASE   = 2'd1;
	localparam logic [1:0] CFG_RING_SIZE  = 2'd2;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_SET_IDX = 2'd1,
		OP_LOOKUP  = 2'd2,
		OP_NOP     = 2'd3
	} stm_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OFS,
		ST_POSDIV,
		ST_IDXDIV,
		ST_READ,
		ST_TEST,
		ST_NEGDIV
	} stm_state_t;

	typedef struct packed {
		logic             acc_init;
		logic             acc_fin;
		logic             div_load;
		logic [DIV_W-1:0] div_num;
		logic [BLK_W-1:0] div_den;
		logic             pos_ld;
		logic             idx_ld;
		logic             rd_en;
		logic             adv;
		logic             clr_we;
		logic             out_ld;
		logic             out_hit;
	} stm_ctl_t;

endpackage

// ----- rtl/stream_timestamp_matcher_core.sv -----
// Timestamp matcher. Op 0 stores an entry (pts, dts, byte region) into the ring, op 1 sets
// the write index and live count, and both answer in the cycle after acceptance with found = 0
// and -1/-1; op 3 answers the same way and changes nothing. Op 2 is a lookup: it turns the
// DMA address, FIFO fill and bit pointer into a read offset in the circular stream buffer,
// then walks the newest live entries oldest first and returns the first whose region holds
// the offset, marking it consumed. A lookup runs through one shared remainder unit that
// produces one bit per cycle: one pass for the buffer offset, one for the starting ring
// slot, then a read and a test state per scanned entry, plus one more pass for an entry
// with zero length that lies exactly a whole number of blocks behind the offset.
// in_stall stays high while a lookup runs and while a result waits on a stalled output.
module stream_timestamp_matcher_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [stm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          op,
	input  logic [31:0]                         dma_addr,
	input  logic [31:0]                         fifo_status,
	input  logic [6:0]                          bit_pointer,
	input  logic [5:0]                          slot,
	input  logic [6:0]                          entry_count,
	input  logic signed [63:0]                  pts_in,
	input  logic signed [63:0]                  dts_in,
	input  logic [23:0]                         region_start,
	input  logic [24:0]                         region_len,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                found,
	output logic signed [63:0]                  pts_out,
	output logic signed [63:0]                  dts_out
);

	localparam int IW = stm_pkg::RING_IW;
	localparam int CW = stm_pkg::RING_CW;
	localparam int BW = stm_pkg::BLK_W;
	localparam int SW = stm_pkg::SIZE_W;
	localparam int PW = stm_pkg::POS_W;
	localparam int DW = stm_pkg::DIV_W;
	localparam int BS = stm_pkg::BLOCK_SHIFT;

	stm_pkg::stm_state_t state_q, state_d;
	stm_pkg::stm_ctl_t   ctl;

	// configuration
	logic [BW-1:0] buf_blocks_q;
	logic [31:0]   buf_base_q;
	logic [6:0]    ring_size_q;

	// ring control
	logic [IW-1:0] write_index_q;
	logic [6:0]    live_count_q;

	// ring storage
	logic [63:0] mem_pts   [stm_pkg::RING_DEPTH];
	logic [63:0] mem_dts   [stm_pkg::RING_DEPTH];
	logic [23:0] mem_start [stm_pkg::RING_DEPTH];
	logic [24:0] mem_len   [stm_pkg::RING_DEPTH];
	logic [63:0] rd_pts_q, rd_dts_q;
	logic [23:0] rd_start_q;
	logic [24:0] rd_len_q;

	// lookup datapath
	logic [31:0]   acc_q;
	logic [PW-1:0] pos_q;
	logic [IW-1:0] k_q;
	logic [CW-1:0] i_q, cnt_q;

	// remainder unit
	logic [DW-1:0]                  div_num_q;
	logic [BW-1:0]                  div_den_q, div_rem_q;
	logic [stm_pkg::DIV_CNT_W-1:0]  div_cnt_q;
	logic                           div_done;
	logic [BW:0]                    div_t;
	logic                           div_ge;

	// output register
	logic        out_valid_q;
	logic        found_q;
	logic [63:0] pts_q, dts_q;

	logic [BW-1:0] blk_eff;
	logic [CW-1:0] ring_eff;
	logic [SW-1:0] size;
	logic          in_acc;
	logic [4:0]    fifo_qw;
	logic [31:0]   acc_init_v, pos32;
	logic [7:0]    first_idx;
	logic [CW-1:0] cnt_v;

	logic signed [SW+1:0] d_s;
	logic [SW:0]          d_u, r_u;
	logic [SW+1:0]        negd_full;
	logic [PW-1:0]        negd;
	logic                 d_neg;
	logic                 test_hit, test_neg, neg_hit;
	logic                 scan_hit, scan_miss, scan_last;

	logic          wr_entry;
	logic          ts_we;
	logic [IW-1:0] wr_addr;
	logic [63:0]   wr_pts, wr_dts;

	// effective buffer size and ring size
	always_comb begin
		if (buf_blocks_q == '0)
			blk_eff = BW'(1);
		else if (buf_blocks_q > BW'(stm_pkg::MAX_BUF_BLOCKS))
			blk_eff = BW'(stm_pkg::MAX_BUF_BLOCKS);
		else
			blk_eff = buf_blocks_q;
		if (ring_size_q == '0)
			ring_eff = CW'(1);
		else if (ring_size_q > 7'(stm_pkg::RING_DEPTH))
			ring_eff = CW'(stm_pkg::RING_DEPTH);
		else
			ring_eff = CW'(ring_size_q);
	end

	assign size     = {blk_eff, {BS{1'b0}}};
	assign in_stall = (state_q != stm_pkg::ST_IDLE) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;

	assign fifo_qw    = 5'(fifo_status[17:16]) + 5'(fifo_status[11:8]);
	assign acc_init_v = dma_addr + 32'(bit_pointer[6:3]) - 32'({fifo_qw, 4'b0000});
	assign pos32      = acc_q + 32'(size) - buf_base_q;
	assign cnt_v      = (CW'(live_count_q) < ring_eff) ? CW'(live_count_q) : ring_eff;
	assign first_idx  = 8'(write_index_q) + 8'(ring_eff) - 8'(cnt_q);

	// region test on the entry just read
	always_comb begin
		d_s = $signed({3'b000, pos_q}) + $signed({2'b00, size})
			- $signed({3'b000, rd_start_q});
		d_neg     = d_s[SW+1];
		d_u       = d_s[SW:0];
		r_u       = (d_u >= {1'b0, size}) ? d_u - {1'b0, size} : d_u;
		negd_full = -d_s;
		negd      = negd_full[PW-1:0];
		if (d_neg) begin
			test_hit = (rd_len_q != '0) || (negd[BS-1:0] != '0);
			test_neg = (rd_len_q == '0) && (negd[BS-1:0] == '0);
		end else begin
			test_hit = r_u < {1'b0, rd_len_q};
			test_neg = 1'b0;
		end
	end

	assign div_done  = (div_cnt_q == '0);
	assign neg_hit   = (div_rem_q != '0);
	assign scan_hit  = ((state_q == stm_pkg::ST_TEST) && test_hit)
		|| ((state_q == stm_pkg::ST_NEGDIV) && div_done && neg_hit);
	assign scan_miss = ((state_q == stm_pkg::ST_TEST) && !test_hit && !test_neg)
		|| ((state_q == stm_pkg::ST_NEGDIV) && div_done && !neg_hit);
	assign scan_last = ((i_q + CW'(1)) == cnt_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stm_pkg::ST_IDLE: begin
				if (in_acc && (op == stm_pkg::OP_LOOKUP))
					state_d = stm_pkg::ST_OFS;
			end
			stm_pkg::ST_OFS:    state_d = stm_pkg::ST_POSDIV;
			stm_pkg::ST_POSDIV: begin
				if (div_done)
					state_d = stm_pkg::ST_IDXDIV;
			end
			stm_pkg::ST_IDXDIV: begin
				if (div_done)
					state_d = (cnt_q == '0) ? stm_pkg::ST_IDLE : stm_pkg::ST_READ;
			end
			stm_pkg::ST_READ:   state_d = stm_pkg::ST_TEST;
			stm_pkg::ST_TEST, stm_pkg::ST_NEGDIV: begin
				if (scan_hit)
					state_d = stm_pkg::ST_IDLE;
				else if (scan_miss)
					state_d = scan_last ? stm_pkg::ST_IDLE : stm_pkg::ST_READ;
				else if (state_q == stm_pkg::ST_TEST)
					state_d = stm_pkg::ST_NEGDIV;
			end
			default:            state_d = stm_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctl = '0;
		unique case (state_q)
			stm_pkg::ST_IDLE: begin
				if (in_acc) begin
					ctl.acc_init = (op == stm_pkg::OP_LOOKUP);
					ctl.out_ld   = (op != stm_pkg::OP_LOOKUP);
				end
			end
			stm_pkg::ST_OFS: begin
				ctl.acc_fin  = 1'b1;
				ctl.div_load = 1'b1;
				ctl.div_num  = pos32[31:BS];
				ctl.div_den  = blk_eff;
			end
			stm_pkg::ST_POSDIV: begin
				if (div_done) begin
					ctl.pos_ld   = 1'b1;
					ctl.div_load = 1'b1;
					ctl.div_num  = DW'(first_idx);
					ctl.div_den  = BW'(ring_eff);
				end
			end
			stm_pkg::ST_IDXDIV: begin
				if (div_done) begin
					ctl.idx_ld = 1'b1;
					ctl.out_ld = (cnt_q == '0);
				end
			end
			stm_pkg::ST_READ:   ctl.rd_en = 1'b1;
			stm_pkg::ST_TEST, stm_pkg::ST_NEGDIV: begin
				if (scan_hit) begin
					ctl.clr_we  = 1'b1;
					ctl.out_ld  = 1'b1;
					ctl.out_hit = 1'b1;
				end else if (scan_miss) begin
					ctl.adv    = 1'b1;
					ctl.out_ld = scan_last;
				end else if (state_q == stm_pkg::ST_TEST) begin
					// entry sits a whole number of blocks behind: check divisibility by the buffer size
					ctl.div_load = 1'b1;
					ctl.div_num  = DW'(negd[PW-1:BS]);
					ctl.div_den  = blk_eff;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= stm_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_blocks_q <= BW'(1);
			buf_base_q   <= '0;
			ring_size_q  <= 7'(stm_pkg::RING_DEPTH);
		end else if (cfg_we) begin
			unique case (cfg_index)
				stm_pkg::CFG_BUF_BLOCKS: buf_blocks_q <= cfg_data[BW-1:0];
				stm_pkg::CFG_BUF_BASE:   buf_base_q   <= cfg_data[31:0];
				stm_pkg::CFG_RING_SIZE:  ring_size_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_index_q <= '0;
			live_count_q  <= '0;
		end else if (in_acc && (op == stm_pkg::OP_SET_IDX)) begin
			write_index_q <= slot[IW-1:0];
			live_count_q  <= entry_count;
		end else if (ctl.clr_we && (live_count_q != '0)) begin
			live_count_q <= live_count_q - 7'd1;
		end
	end

	// shared remainder unit, restoring, msb first
	assign div_t  = {div_rem_q, div_num_q[DW-1]};
	assign div_ge = (div_t >= {1'b0, div_den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_cnt_q <= '0;
		else if (ctl.div_load)
			div_cnt_q <= stm_pkg::DIV_CNT_W'(DW);
		else if (!div_done)
			div_cnt_q <= div_cnt_q - stm_pkg::DIV_CNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (ctl.div_load) begin
			div_num_q <= ctl.div_num;
			div_den_q <= ctl.div_den;
			div_rem_q <= '0;
		end else if (!div_done) begin
			div_num_q <= {div_num_q[DW-2:0], 1'b0};
			div_rem_q <= div_ge ? BW'(div_t - {1'b0, div_den_q}) : div_t[BW-1:0];
		end
	end

	// lookup datapath
	always_ff @(posedge clk) begin
		if (ctl.acc_init) begin
			acc_q <= acc_init_v;
			cnt_q <= cnt_v;
		end else if (ctl.acc_fin) begin
			acc_q <= pos32;
		end
		if (ctl.pos_ld)
			pos_q <= {div_rem_q[PW-BS-1:0], acc_q[BS-1:0]};
		if (ctl.idx_ld) begin
			k_q <= div_rem_q[IW-1:0];
			i_q <= '0;
		end else if (ctl.adv) begin
			k_q <= ((CW'(k_q) + CW'(1)) == ring_eff) ? '0 : k_q + IW'(1);
			i_q <= i_q + CW'(1);
		end
	end

	// ring storage: one write port shared by entry load and consume, one read port
	assign wr_entry = in_acc && (op == stm_pkg::OP_WRITE)
		&& ({1'b0, slot} < CW'(stm_pkg::RING_DEPTH));
	assign ts_we    = wr_entry || ctl.clr_we;
	assign wr_addr  = wr_entry ? slot[IW-1:0] : k_q;
	assign wr_pts   = wr_entry ? pts_in : '1;
	assign wr_dts   = wr_entry ? dts_in : '1;

	always_ff @(posedge clk) begin
		if (ts_we) begin
			mem_pts[wr_addr] <= wr_pts;
			mem_dts[wr_addr] <= wr_dts;
		end
		if (wr_entry) begin
			mem_start[wr_addr] <= region_start;
			mem_len[wr_addr]   <= region_len;
		end
		if (ctl.rd_en) begin
			rd_pts_q   <= mem_pts[k_q];
			rd_dts_q   <= mem_dts[k_q];
			rd_start_q <= mem_start[k_q];
			rd_len_q   <= mem_len[k_q];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.out_ld)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.out_ld) begin
			found_q <= ctl.out_hit;
			pts_q   <= ctl.out_hit ? rd_pts_q : '1;
			dts_q   <= ctl.out_hit ? rd_dts_q : '1;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign pts_out   = pts_q;
	assign dts_out   = dts_q;

endmodule

// ----- rtl/stm_checker.sv -----
module stm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic [1:0]                     cfg_index,
	input logic [stm_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic [1:0]                     op,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           found,
	input logic [63:0]                    pts_out,
	input logic [63:0]                    dts_out
);

	logic in_acc;
	logic cfg_seen;

	assign in_acc   = in_valid && !in_stall;
	assign cfg_seen = cfg_we && (cfg_index != stm_pkg::CFG_BUF_BLOCKS || cfg_data != '0);

	// a non-lookup transaction answers on the next cycle
	a_quick_answer: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (op != stm_pkg::OP_LOOKUP) |=> out_valid)
		else $error("non-lookup transaction gave no result on the next cycle");

	// a lookup stalls the input right after it is taken
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (op == stm_pkg::OP_LOOKUP) |=> in_stall)
		else $error("input taken again right after a lookup");

	// a miss always carries the all-ones timestamps
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (pts_out == '1) && (dts_out == '1))
		else $error("miss result carries a timestamp");

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && !cfg_seen |=> out_valid && $stable(pts_out)
			&& $stable(dts_out) && $stable(found))
		else $error("stalled result changed");

endmodule

bind stream_timestamp_matcher_core stm_checker u_stm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.op        (op),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.found     (found),
	.pts_out   (pts_out),
	.dts_out   (dts_out)
);
